// File: hdl/dq_pkg.sv
// Shared constants, opcodes and control structs for the double-ended queue.
// Used by the pointer unit and the top level; no dependencies.
`default_nettype none

package dq_pkg;

   // Ring buffer geometry
   localparam int DEPTH    = 1024;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = CNT_W + 1;

   // Payload widths
   localparam int VALUE_W      = 17;
   localparam int RESULT_W     = 18;
   localparam int OPCODE_W     = 3;
   localparam int REQ_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

   localparam logic [VALUE_W-1:0]  VALUE_MAX = VALUE_W'(100000);
   localparam logic [RESULT_W-1:0] MINUS_ONE = {RESULT_W{1'b1}};

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SIZE       = 3'd4,
      OP_EMPTY      = 3'd5,
      OP_PEEK_FRONT = 3'd6,
      OP_PEEK_BACK  = 3'd7
   } op_type;

   // Pointer update pulses, at most one high per cycle
   typedef struct packed {
      logic add_front;
      logic add_back;
      logic take_front;
      logic take_back;
   } ptr_upd_type;

   // Pointer status and derived memory indexes
   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic              empty;
      logic              full;
      logic [ADDR_W-1:0] front_idx;
      logic [ADDR_W-1:0] back_idx;
      logic [ADDR_W-1:0] ins_front_idx;
      logic [ADDR_W-1:0] ins_back_idx;
   } ptr_stat_type;

   // Fold a sum below 2*DEPTH back into the ring
   function automatic logic [ADDR_W-1:0] wrap_index(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] adj;
      adj = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
      return adj[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/dq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency; sized by WIDTH and DEPTH.
`default_nettype none

module dq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hdl/dq_ptr.sv
// Head pointer and entry count of the ring buffer, plus the memory indexes
// derived from them. Depends on dq_pkg.
`default_nettype none

module dq_ptr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dq_pkg::ptr_upd_type  upd,
   output dq_pkg::ptr_stat_type      stat
);
   import dq_pkg::*;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] head_dec;

   assign head_dec = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - ADDR_W'(1);

   // Derive indexes from the current pointers
   always_comb begin
      stat.count         = count_ff;
      stat.empty         = (count_ff == '0);
      stat.full          = (count_ff == CNT_W'(DEPTH));
      stat.front_idx     = head_ff;
      stat.ins_front_idx = head_dec;
      stat.back_idx      = wrap_index(SUM_W'(head_ff) + SUM_W'(count_ff) - SUM_W'(1));
      stat.ins_back_idx  = wrap_index(SUM_W'(head_ff) + SUM_W'(count_ff));
   end

   // Advance head and count on each committed update
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      priority if (upd.add_front) begin
         head_in  = head_dec;
         count_in = count_ff + CNT_W'(1);
      end else if (upd.add_back) begin
         count_in = count_ff + CNT_W'(1);
      end else if (upd.take_front) begin
         head_in  = wrap_index(SUM_W'(head_ff) + SUM_W'(1));
         count_in = count_ff - CNT_W'(1);
      end else if (upd.take_back) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         // Hold both pointers
         head_in  = head_ff;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/double_ended_queue.sv
// Double-ended queue: 17-bit values held in a ring buffer RAM.
// Size, empty, refused pushes and pops or peeks on an empty deque answer in the
// cycle after the beat is accepted; other pops and peeks pass the read state,
// set by the RAM read. Throughput: one beat per cycle for pushes, size and empty while
// the result slot is free or draining; pops and peeks stall new beats on the single RAM read port.
// Reset (synchronous, active high) empties the deque; RAM contents are kept.
`default_nettype none

module double_ended_queue (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [dq_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [16:0] value, rest zero
   input  wire logic [dq_pkg::OPCODE_W-1:0]        req_tuser,  // [2:0] opcode
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [dq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // [17:0] result_value, rest zero
   output logic                                    rsp_tuser   // [0] rejected
);
   import dq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                  rsp_rej_ff, rsp_rej_in;

   ptr_upd_type           upd;
   ptr_stat_type          stat;

   logic                  req_accept;
   op_type                opcode;
   logic [VALUE_W-1:0]    value;
   logic                  value_ok;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic                  ram_re;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [VALUE_W-1:0]    ram_rdata;

   assign opcode   = op_type'(req_tuser);
   assign value    = req_tdata[VALUE_W-1:0];
   assign value_ok = (value != '0) && (value <= VALUE_MAX);

   // Take a beat when idle and the result slot is free or draining
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   dq_ptr u_ptr (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .stat  (stat)
   );

   dq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (value),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Decode the accepted beat into pointer updates, RAM access and result
   always_comb begin
      upd          = '0;
      ram_we       = 1'b0;
      ram_waddr    = stat.ins_back_idx;
      ram_re       = 1'b0;
      ram_raddr    = stat.front_idx;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_rej_in   = rsp_rej_ff;

      if (state_ff == ST_READ) begin
         // Deliver the value read from the ring
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_value_in = RESULT_W'(ram_rdata);
         rsp_rej_in   = 1'b0;
      end else if (req_accept) begin
         unique case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (!value_ok || stat.full) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = MINUS_ONE;
                  rsp_rej_in   = 1'b1;
               end else begin
                  ram_we = 1'b1;
                  if (opcode == OP_PUSH_FRONT) begin
                     ram_waddr     = stat.ins_front_idx;
                     upd.add_front = 1'b1;
                  end else begin
                     ram_waddr    = stat.ins_back_idx;
                     upd.add_back = 1'b1;
                  end
               end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
               if (stat.empty) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = MINUS_ONE;
                  rsp_rej_in   = 1'b0;
               end else begin
                  ram_re   = 1'b1;
                  state_in = ST_READ;
                  if (opcode == OP_POP_BACK || opcode == OP_PEEK_BACK) begin
                     ram_raddr = stat.back_idx;
                  end
                  upd.take_front = (opcode == OP_POP_FRONT);
                  upd.take_back  = (opcode == OP_POP_BACK);
               end
            end
            OP_SIZE: begin
               rsp_valid_in = 1'b1;
               rsp_value_in = RESULT_W'(stat.count);
               rsp_rej_in   = 1'b0;
            end
            OP_EMPTY: begin
               rsp_valid_in = 1'b1;
               rsp_value_in = RESULT_W'(stat.empty);
               rsp_rej_in   = 1'b0;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_tready;
            end
         endcase
      end
   end

   // Hold state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_rej_ff;

   // The read state always finds the result slot empty
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("read result would overwrite a pending beat");

   // No RAM write while a read is in flight
   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE)
      else $error("RAM write during read state");

   // Count never passes the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // A stored push grows the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> stat.count == $past(stat.count) + CNT_W'(1))
      else $error("push did not advance the count");

   // The read state of a pop or peek on a non-empty deque answers in the next cycle
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_valid_ff && !rsp_rej_ff)
      else $error("read did not produce a result");

endmodule

`default_nettype wire
